// ----- src/lsh_pkg.sv -----
// ----------------------------------------------------------------------------
// lsh_pkg: shared constants, types and helpers
// Widths, register indices and small helpers for the five-point stencil core.
// ----------------------------------------------------------------------------
`default_nettype none

package lsh_pkg;

  localparam int MAX_ROWS = 64;
  localparam int MAX_COLS = 64;

  localparam int DATA_W = 32;
  localparam int CNT_W  = 7;
  localparam int ROW_W  = $clog2(MAX_ROWS);
  localparam int COL_W  = $clog2(MAX_COLS);

  // a - 2b + c of three 32-bit signed values stays inside +/-(2^33 - 2)
  localparam int DIFF_W = DATA_W + 2;
  localparam int MAG_W  = DATA_W + 1;
  localparam int PROD_W = 2 * DATA_W;
  localparam int P_W    = DATA_W + 2;
  localparam int SUM_W  = DATA_W + 4;

  localparam logic [DATA_W-1:0] COEF_RESET  = DATA_W'(87961);
  localparam logic [CNT_W-1:0]  COUNT_RESET = CNT_W'(64);
  localparam logic [CNT_W-1:0]  COUNT_MIN   = CNT_W'(3);

  typedef enum logic [2:0] {
    REG_MODE      = 3'd0,
    REG_COEF_X    = 3'd1,
    REG_COEF_Y    = 3'd2,
    REG_ROW_COUNT = 3'd3,
    REG_COL_COUNT = 3'd4
  } reg_idx_t;

  // stage enables handed to a scaling lane
  typedef struct packed {
    logic load_mul;
    logic load_out;
  } lane_en_t;

  function automatic logic [CNT_W-1:0] clamp_count(input logic [CNT_W-1:0] v,
                                                   input int unsigned hi);
    int unsigned vi;
    vi = 32'(v);
    if (v < COUNT_MIN) return COUNT_MIN;
    if (vi > hi) return CNT_W'(hi);
    return v;
  endfunction

  function automatic logic signed [DIFF_W-1:0] sx_diff(input logic [DATA_W-1:0] v);
    return DIFF_W'($signed(v));
  endfunction

endpackage

`default_nettype wire

// ----- src/lsh_line_bank.sv -----
// ----------------------------------------------------------------------------
// lsh_line_bank: one row of the other-value line store
// One write port and two registered read ports (column and column plus one).
// ----------------------------------------------------------------------------
`default_nettype none

module lsh_line_bank
  import lsh_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [COL_W-1:0]  wa,
  input  wire logic [DATA_W-1:0] wd,
  input  wire logic              re,
  input  wire logic [COL_W-1:0]  ra,
  input  wire logic [COL_W-1:0]  rb,
  output logic      [DATA_W-1:0] rd_a,
  output logic      [DATA_W-1:0] rd_b
);

  logic [DATA_W-1:0] mem [MAX_COLS];
  logic [DATA_W-1:0] rd_a_r;
  logic [DATA_W-1:0] rd_b_r;

  // read-before-write on a shared address
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      rd_a_r <= mem[ra];
      rd_b_r <= mem[rb];
    end
  end

  assign rd_a = rd_a_r;
  assign rd_b = rd_b_r;

endmodule

`default_nettype wire

// ----- src/lsh_scale_lane.sv -----
// ----------------------------------------------------------------------------
// lsh_scale_lane: coefficient times second difference, shifted by 32
// Two-stage lane: 32x32 partial product, then fold in top bit and re-sign.
// ----------------------------------------------------------------------------
`default_nettype none

module lsh_scale_lane
  import lsh_pkg::*;
(
  input  wire logic                    clk,
  input  wire lane_en_t                en,
  input  wire logic [DATA_W-1:0]       coef,
  input  wire logic                    neg,
  input  wire logic [MAG_W-1:0]        mag,
  output logic signed [P_W-1:0]        p
);

  logic [PROD_W-1:0]        prod_r;
  logic [DATA_W-1:0]        hc_r;
  logic                     neg_r;
  logic [MAG_W-1:0]         sum;
  logic signed [P_W-1:0]    p_nxt;
  logic signed [P_W-1:0]    p_r;

  always_ff @(posedge clk) begin
    if (en.load_mul) begin
      prod_r <= PROD_W'(mag[DATA_W-1:0]) * PROD_W'(coef);
      hc_r   <= mag[MAG_W-1] ? coef : '0;
      neg_r  <= neg;
    end
  end

  // magnitude truncated, sign reapplied: rounds toward zero
  always_comb begin
    sum   = MAG_W'(hc_r) + MAG_W'(prod_r[PROD_W-1:DATA_W]);
    p_nxt = neg_r ? -$signed(P_W'(sum)) : $signed(P_W'(sum));
  end

  always_ff @(posedge clk) begin
    if (en.load_out) begin
      p_r <= p_nxt;
    end
  end

  assign p = p_r;

endmodule

`default_nettype wire

// ----- src/laplacian_stencil_half_step_core.sv -----
// ----------------------------------------------------------------------------
// laplacian_stencil_half_step_core: streaming five-point stencil update
// Raster-order grid in, one row behind out, with saturated fixed-point update.
// ----------------------------------------------------------------------------
//  channel | dir | handshake         | payload
//  in_     | in  | tvalid/tready     | tdata[31:0] own_value, [63:32] other_value
//  out_    | out | tvalid/tready     | tdata new_value, tuser grid_end, tlast last
//  cfg_    | in  | psel/penable      | 4-byte registers: mode, coef_x, coef_y,
//          |     |                   | row_count, col_count
//
//  One input transaction per cycle while out_tready is high; last-row items give
//  two results, so there the output side sets the pace at one result per cycle.
//  Five register stages from acceptance to the first result on the port:
//  line-store read, differences, 32x32 product, re-sign, result register.
//  Reset clears positions, valids and config registers; line stores are not cleared.
//  Each stage moves when its successor is free; out_tready ripples back to
//  in_tready combinationally through the stage valids.
// ----------------------------------------------------------------------------
`default_nettype none

module laplacian_stencil_half_step_core
  import lsh_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  // own_value [31:0], other_value [63:32]
  input  wire logic [63:0]       in_tdata,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  // new_value [31:0]
  output logic [DATA_W-1:0]      out_tdata,
  // grid_end [0]
  output logic                   out_tuser,
  output logic                   out_tlast,
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  input  wire logic              cfg_psel,
  input  wire logic              cfg_penable,
  input  wire logic              cfg_pwrite,
  input  wire logic [4:0]        cfg_paddr,
  input  wire logic [31:0]       cfg_pwdata,
  output logic [31:0]            cfg_prdata,
  output logic                   cfg_pready
);

  typedef struct packed {
    logic              emit;
    logic              inner;
    logic              lrow;
    logic              lcol;
    logic [DATA_W-1:0] own_in;
    logic [DATA_W-1:0] prev_own;
  } side_t;

  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic              grid_end;
    logic              last;
  } result_t;

  // ---------------------------------------------------------------- config
  logic              mode_r;
  logic [DATA_W-1:0] coef_x_r;
  logic [DATA_W-1:0] coef_y_r;
  logic [CNT_W-1:0]  row_cnt_r;
  logic [CNT_W-1:0]  col_cnt_r;
  logic              cfg_wr;
  reg_idx_t          cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[4:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= 1'b0;
      coef_x_r  <= COEF_RESET;
      coef_y_r  <= COEF_RESET;
      row_cnt_r <= COUNT_RESET;
      col_cnt_r <= COUNT_RESET;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_MODE:      mode_r    <= cfg_pwdata[0];
        REG_COEF_X:    coef_x_r  <= cfg_pwdata;
        REG_COEF_Y:    coef_y_r  <= cfg_pwdata;
        REG_ROW_COUNT: row_cnt_r <= cfg_pwdata[CNT_W-1:0];
        REG_COL_COUNT: col_cnt_r <= cfg_pwdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_MODE:      cfg_prdata = {31'b0, mode_r};
      REG_COEF_X:    cfg_prdata = coef_x_r;
      REG_COEF_Y:    cfg_prdata = coef_y_r;
      REG_ROW_COUNT: cfg_prdata = 32'(row_cnt_r);
      REG_COL_COUNT: cfg_prdata = 32'(col_cnt_r);
      default:       cfg_prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- handshake chain
  logic s1_v_r, s2_v_r, s3_v_r, s4_v_r;
  logic en_1, en_2, en_3, en_4, en_p;
  logic accept;

  assign en_4      = !s4_v_r || en_p;
  assign en_3      = !s3_v_r || en_4;
  assign en_2      = !s2_v_r || en_3;
  assign en_1      = !s1_v_r || en_2;
  assign in_tready = en_1;
  assign accept    = in_tvalid && in_tready;

  // ---------------------------------------------------------------- positions
  logic [ROW_W-1:0]  row_pos_r;
  logic [COL_W-1:0]  col_pos_r;
  logic [CNT_W-1:0]  rows, cols;
  logic [ROW_W-1:0]  r;
  logic [COL_W-1:0]  c;
  logic [COL_W-1:0]  c_next;
  logic              last_row, last_col, emit, inner;
  logic [DATA_W-1:0] own_in, oth_in;

  assign own_in = in_tdata[DATA_W-1:0];
  assign oth_in = in_tdata[2*DATA_W-1:DATA_W];

  always_comb begin
    rows     = clamp_count(row_cnt_r, MAX_ROWS);
    cols     = clamp_count(col_cnt_r, MAX_COLS);
    // position saturates if the counts shrank under it
    r        = (CNT_W'(row_pos_r) > rows - 1'b1) ? ROW_W'(rows - 1'b1) : row_pos_r;
    c        = (CNT_W'(col_pos_r) > cols - 1'b1) ? COL_W'(cols - 1'b1) : col_pos_r;
    c_next   = c + 1'b1;
    last_row = (CNT_W'(r) == rows - 1'b1);
    last_col = (CNT_W'(c) == cols - 1'b1);
    emit     = (r != '0);
    inner    = (r > ROW_W'(1)) && (c != '0) && (CNT_W'(c) + 1'b1 < cols);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_pos_r <= '0;
      col_pos_r <= '0;
    end else if (accept) begin
      if (last_col) begin
        col_pos_r <= '0;
        row_pos_r <= last_row ? '0 : r + 1'b1;
      end else begin
        col_pos_r <= c_next;
        row_pos_r <= r;
      end
    end
  end

  // ---------------------------------------------------------------- line stores
  logic [DATA_W-1:0] b0_a, b0_b, b1_a, b1_b;
  logic [DATA_W-1:0] own_mem [MAX_COLS];
  logic [DATA_W-1:0] own_rd_r;

  lsh_line_bank u_bank0 (
    .clk  (clk),
    .we   (accept && !r[0]),
    .wa   (c),
    .wd   (oth_in),
    .re   (accept),
    .ra   (c),
    .rb   (c_next),
    .rd_a (b0_a),
    .rd_b (b0_b)
  );

  lsh_line_bank u_bank1 (
    .clk  (clk),
    .we   (accept && r[0]),
    .wa   (c),
    .wd   (oth_in),
    .re   (accept),
    .ra   (c),
    .rb   (c_next),
    .rd_a (b1_a),
    .rd_b (b1_b)
  );

  always_ff @(posedge clk) begin
    if (accept) begin
      own_mem[c] <= own_in;
      own_rd_r   <= own_mem[c];
    end
  end

  // ---------------------------------------------------------------- stage 1
  logic              s1_emit_r, s1_inner_r, s1_lrow_r, s1_lcol_r, s1_par_r;
  logic [DATA_W-1:0] s1_own_r, s1_oth_r, s1_win_r;
  logic [DATA_W-1:0] prev_c, prev_c1, cur_c;
  logic [DATA_W-1:0] win_nxt;

  // s1_par_r: bank holding the row of the emitted point
  always_comb begin
    prev_c  = s1_par_r ? b1_a : b0_a;
    prev_c1 = s1_par_r ? b1_b : b0_b;
    cur_c   = s1_par_r ? b0_a : b1_a;
    // left neighbour is what the last transaction read; on a bank swap it is
    // what the last transaction wrote
    win_nxt = (s1_par_r == !r[0]) ? prev_c : s1_oth_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (accept) begin
      s1_v_r <= 1'b1;
    end else if (en_2) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_emit_r  <= emit;
      s1_inner_r <= inner;
      s1_lrow_r  <= last_row;
      s1_lcol_r  <= last_col;
      s1_par_r   <= !r[0];
      s1_own_r   <= own_in;
      s1_oth_r   <= oth_in;
      s1_win_r   <= win_nxt;
    end
  end

  // ---------------------------------------------------------------- stage 2
  logic signed [DIFF_W-1:0] drow, dcol;
  logic [MAG_W-1:0]         mag_x, mag_y;
  logic                     s2_neg_x_r, s2_neg_y_r;
  logic [MAG_W-1:0]         s2_mag_x_r, s2_mag_y_r;
  side_t                    s1_side, s2_side_r, s3_side_r, s4_side_r;

  always_comb begin
    drow  = sx_diff(s1_oth_r) - (sx_diff(prev_c) <<< 1) + sx_diff(cur_c);
    dcol  = sx_diff(prev_c1) - (sx_diff(prev_c) <<< 1) + sx_diff(s1_win_r);
    mag_x = drow[DIFF_W-1] ? MAG_W'(-drow) : MAG_W'(drow);
    mag_y = dcol[DIFF_W-1] ? MAG_W'(-dcol) : MAG_W'(dcol);
    s1_side = '{emit: s1_emit_r, inner: s1_inner_r, lrow: s1_lrow_r,
                lcol: s1_lcol_r, own_in: s1_own_r, prev_own: own_rd_r};
  end

  always_ff @(posedge clk) begin
    if (en_2) begin
      s2_neg_x_r <= drow[DIFF_W-1];
      s2_neg_y_r <= dcol[DIFF_W-1];
      s2_mag_x_r <= mag_x;
      s2_mag_y_r <= mag_y;
      s2_side_r  <= s1_side;
    end
    if (en_3) s3_side_r <= s2_side_r;
    if (en_4) s4_side_r <= s3_side_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
    end else begin
      if (en_2) s2_v_r <= s1_v_r;
      if (en_3) s3_v_r <= s2_v_r;
      if (en_4) s4_v_r <= s3_v_r;
    end
  end

  // ---------------------------------------------------------------- stages 3, 4
  logic signed [P_W-1:0] p_x, p_y;
  lane_en_t              lane_en;

  assign lane_en = '{load_mul: en_3, load_out: en_4};

  lsh_scale_lane u_lane_x (
    .clk  (clk),
    .en   (lane_en),
    .coef (coef_x_r),
    .neg  (s2_neg_x_r),
    .mag  (s2_mag_x_r),
    .p    (p_x)
  );

  lsh_scale_lane u_lane_y (
    .clk  (clk),
    .en   (lane_en),
    .coef (coef_y_r),
    .neg  (s2_neg_y_r),
    .mag  (s2_mag_y_r),
    .p    (p_y)
  );

  // ---------------------------------------------------------------- result register
  logic signed [SUM_W-1:0] lap, own_ext, upd;
  logic [DATA_W-1:0]       sat_val;
  result_t                 res0_r, res1_r;
  logic                    pv_r, sel_r, two_r;
  logic                    take, fin;

  always_comb begin
    lap     = SUM_W'(p_x) + SUM_W'(p_y);
    own_ext = SUM_W'($signed(s4_side_r.prev_own));
    upd     = mode_r ? own_ext + lap : own_ext - lap;
    if (upd[SUM_W-1:DATA_W-1] == '0 || upd[SUM_W-1:DATA_W-1] == '1) begin
      sat_val = upd[DATA_W-1:0];
    end else begin
      sat_val = upd[SUM_W-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
    end
  end

  assign take = out_tvalid && out_tready;
  assign fin  = take && (sel_r || !two_r);
  assign en_p = !pv_r || fin;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r  <= 1'b0;
      sel_r <= 1'b0;
      two_r <= 1'b0;
    end else if (en_p) begin
      pv_r  <= s4_v_r && s4_side_r.emit;
      sel_r <= 1'b0;
      two_r <= s4_side_r.lrow;
    end else if (take) begin
      sel_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en_p) begin
      res0_r <= '{value:    s4_side_r.inner ? sat_val : s4_side_r.prev_own,
                  grid_end: 1'b0,
                  last:     !s4_side_r.lrow};
      res1_r <= '{value: s4_side_r.own_in, grid_end: s4_side_r.lcol, last: 1'b1};
    end
  end

  assign out_tvalid = pv_r;
  assign out_tdata  = sel_r ? res1_r.value    : res0_r.value;
  assign out_tuser  = sel_r ? res1_r.grid_end : res0_r.grid_end;
  assign out_tlast  = sel_r ? res1_r.last     : res0_r.last;

  // ---------------------------------------------------------------- checks
  a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast)
    else $error("grid end on a result that is not the last of its transaction");

  a_pair_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=> out_tvalid && out_tlast)
    else $error("first result of a pair not followed by its second");

  // only interior points use the read data, and only they are sure to read
  // entries already written
  a_s1_read_held: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r && s1_inner_r && !en_2 |=> $stable(prev_c) && $stable(cur_c) && $stable(prev_c1))
    else $error("line-store read data changed under a held stage-1 item");

  a_no_accept_while_full: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r && s2_v_r && s3_v_r && s4_v_r && pv_r && !out_tready |-> !in_tready)
    else $error("input taken with every stage occupied and output stalled");

endmodule

`default_nettype wire

// ----- dv/laplacian_stencil_half_step_core_test.sv -----
// ----------------------------------------------------------------------------
// laplacian_stencil_half_step_core_test: self-checking bench for the stencil core
// Streams raster-order grids through the core, predicts every updated point
// (line stores, Q0.32 scaling, saturation, boundary pass-through, last-row
// double emission) and checks each output transaction field by field. Covers
// register readback, clamped counts, a mid-grid shrink of the counts, random
// grids up to the largest sizes, random idling on both sides and a long
// output stall.
// ----------------------------------------------------------------------------
`default_nettype none

module laplacian_stencil_half_step_core_test;
  import lsh_pkg::*;

  localparam int     RANDOM_ITEMS   = 390;
  localparam int     CYCLE_LIMIT    = 200000;
  localparam int     SHOWN_FAILURES = 10;
  localparam int     SETTLE_CYCLES  = 10;
  localparam longint Q_HI           = 2147483647;
  localparam longint Q_LO           = -Q_HI - 1;
  localparam logic [31:0] QMAX      = 32'h7FFF_FFFF;
  localparam logic [31:0] QMIN      = 32'h8000_0000;

  typedef struct packed {
    logic [31:0] value;
    logic        grid_end;
    logic        last;
  } stencil_point_t;

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic [63:0] in_tdata    = '0;
  logic        in_tvalid   = 1'b0;
  logic        in_tready;
  logic [31:0] out_tdata;
  logic        out_tuser;
  logic        out_tlast;
  logic        out_tvalid;
  logic        out_tready  = 1'b0;
  logic        cfg_psel    = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite  = 1'b0;
  logic [4:0]  cfg_paddr   = '0;
  logic [31:0] cfg_pwdata  = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  laplacian_stencil_half_step_core DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always #6 clk = ~clk;

  // shadow of the core: registers, line stores, raster position
  logic [31:0]    reg_shadow [5];
  logic [31:0]    other_rows [2*MAX_COLS] = '{default: '0};
  logic [31:0]    own_row    [MAX_COLS]   = '{default: '0};
  int             row_at = 0;
  int             col_at = 0;
  stencil_point_t expected_points [$];
  stencil_point_t front_point;

  int send_idle_pct  = 0;
  int recv_idle_pct  = 0;
  int hold_left      = 0;
  int mismatch_count = 0;
  int items_sent     = 0;
  int results_seen   = 0;
  int grids_run      = 0;
  int cycle_count    = 0;

  initial begin
    reg_shadow[REG_MODE]      = '0;
    reg_shadow[REG_COEF_X]    = COEF_RESET;
    reg_shadow[REG_COEF_Y]    = COEF_RESET;
    reg_shadow[REG_ROW_COUNT] = 32'(COUNT_RESET);
    reg_shadow[REG_COL_COUNT] = 32'(COUNT_RESET);
  end

  function automatic int counts_in_use(input logic [31:0] v, input int hi);
    if (v < 3) return 3;
    if (v > hi) return hi;
    return int'(v);
  endfunction

  function automatic longint widen(input logic [31:0] v);
    return longint'($signed(v));
  endfunction

  // (coef * diff) >> 32 with the magnitude truncated
  function automatic longint scaled_term(input logic [31:0] coef, input longint diff);
    logic [33:0] mag;
    logic [65:0] prod;
    mag  = (diff < 0) ? 34'(-diff) : 34'(diff);
    prod = 66'(mag) * 66'(coef);
    return (diff < 0) ? -longint'(prod[65:32]) : longint'(prod[65:32]);
  endfunction

  function automatic logic [31:0] clip_q428(input longint v);
    if (v > Q_HI) return QMAX;
    if (v < Q_LO) return QMIN;
    return v[31:0];
  endfunction

  function automatic logic [31:0] reg_mask(input reg_idx_t idx);
    case (idx)
      REG_MODE:                     return 32'h1;
      REG_ROW_COUNT, REG_COL_COUNT: return 32'h7F;
      default:                      return 32'hFFFF_FFFF;
    endcase
  endfunction

  function automatic logic [31:0] pick_q428();
    logic [19:0] low;
    low = 20'($urandom());
    case ($urandom_range(0, 9))
      0:       return QMAX;
      1:       return QMIN;
      2, 3, 4: return $urandom();
      default: return {{12{low[19]}}, low};
    endcase
  endfunction

  function automatic logic [31:0] pick_coef();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return 32'hFFFF_FFFF;
      2, 3:    return $urandom();
      default: return $urandom_range(0, 1 << 24);
    endcase
  endfunction

  // expected results of one accepted point, then store and position update
  task automatic predict_update(input logic [31:0] own, input logic [31:0] other);
    int             rows, cols, r, c, here, above;
    bit             end_row, end_col;
    longint         mid, drow, dcol, lap, val;
    stencil_point_t pt;
    rows    = counts_in_use(reg_shadow[REG_ROW_COUNT], MAX_ROWS);
    cols    = counts_in_use(reg_shadow[REG_COL_COUNT], MAX_COLS);
    r       = (row_at > rows - 1) ? rows - 1 : row_at;
    c       = (col_at > cols - 1) ? cols - 1 : col_at;
    here    = (r % 2) * MAX_COLS;
    above   = ((r + 1) % 2) * MAX_COLS;
    end_row = (r == rows - 1);
    end_col = (c == cols - 1);
    if (r >= 1) begin
      val = widen(own_row[c]);
      if (r >= 2 && c >= 1 && c + 1 < cols) begin
        mid  = widen(other_rows[above + c]);
        drow = widen(other) - 2 * mid + widen(other_rows[here + c]);
        dcol = widen(other_rows[above + c + 1]) - 2 * mid
             + widen(other_rows[above + c - 1]);
        lap  = scaled_term(reg_shadow[REG_COEF_X], drow)
             + scaled_term(reg_shadow[REG_COEF_Y], dcol);
        val  = reg_shadow[REG_MODE][0] ? val + lap : val - lap;
      end
      pt.value    = clip_q428(val);
      pt.grid_end = 1'b0;
      pt.last     = !end_row;
      expected_points.push_back(pt);
      // last row: its own point follows unchanged
      if (end_row) begin
        pt.value    = own;
        pt.grid_end = end_col;
        pt.last     = 1'b1;
        expected_points.push_back(pt);
      end
    end
    other_rows[here + c] = other;
    own_row[c]           = own;
    if (end_col) begin
      col_at = 0;
      row_at = end_row ? 0 : r + 1;
    end else begin
      col_at = c + 1;
      row_at = r;
    end
  endtask

  task automatic flag_failure(input string what, input logic [31:0] want,
                              input logic [31:0] got);
    mismatch_count++;
    if (mismatch_count <= SHOWN_FAILURES)
      $display("mismatch on %s at result %0d: expected %h, got %h",
               what, results_seen, want, got);
  endtask

  // one input transaction; tvalid stays up until the next call or a drain
  task automatic push_point(input logic [31:0] own, input logic [31:0] other);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tdata  <= {other, own};
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
    predict_update(own, other);
  endtask

  // stop offering, wait for every expected result, then let the pipe settle
  task automatic drain_core();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (expected_points.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_access(input bit is_write, input reg_idx_t idx,
                            input logic [31:0] wdata, output logic [31:0] rdata);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= is_write;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= wdata;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    rdata = cfg_prdata;
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic check_register(input reg_idx_t idx);
    logic [31:0] rdata;
    cfg_access(1'b0, idx, '0, rdata);
    if (rdata !== reg_shadow[idx]) flag_failure(idx.name(), reg_shadow[idx], rdata);
  endtask

  task automatic set_register(input reg_idx_t idx, input logic [31:0] value);
    logic [31:0] unused;
    cfg_access(1'b1, idx, value, unused);
    reg_shadow[idx] = value & reg_mask(idx);
    check_register(idx);
  endtask

  task automatic configure_grid(input bit mode, input logic [31:0] cx, input logic [31:0] cy,
                                input logic [31:0] rows_reg, input logic [31:0] cols_reg);
    drain_core();
    set_register(REG_MODE, 32'(mode));
    set_register(REG_COEF_X, cx);
    set_register(REG_COEF_Y, cy);
    set_register(REG_ROW_COUNT, rows_reg);
    set_register(REG_COL_COUNT, cols_reg);
    grids_run++;
  endtask

  task automatic push_random_grid();
    int n;
    n = counts_in_use(reg_shadow[REG_ROW_COUNT], MAX_ROWS)
      * counts_in_use(reg_shadow[REG_COL_COUNT], MAX_COLS);
    repeat (n) push_point(pick_q428(), pick_q428());
  endtask

  task automatic test_register_reset_values();
    check_register(REG_MODE);
    check_register(REG_COEF_X);
    check_register(REG_COEF_Y);
    check_register(REG_ROW_COUNT);
    check_register(REG_COL_COUNT);
  endtask

  // 3x4 grid, full-scale coefficients: both interior points saturate,
  // one low and one high; boundary points carry every extreme
  task automatic test_saturation_and_boundaries();
    logic [31:0] other_tbl [12];
    logic [31:0] own_tbl   [12];
    other_tbl = '{32'h0, QMAX, QMIN, 32'hFFFF_FFFF,
                  QMAX, QMIN, QMAX, QMIN,
                  32'h1000_0000, QMAX, QMIN, 32'h0};
    own_tbl   = '{QMAX, QMIN, 32'hFFFF_FFFF, 32'h0,
                  32'h5555_5555, QMIN, QMAX, 32'hAAAA_AAAA,
                  QMIN, 32'h0000_0001, 32'hF000_0000, QMAX};
    // a row count below the minimum is taken as three
    configure_grid(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 32'd4);
    for (int i = 0; i < 12; i++) push_point(own_tbl[i], other_tbl[i]);
  endtask

  // counts shrink while the raster sits beyond them: position clamps to the
  // last row and column, the grid ends and the raster wraps
  task automatic test_mid_grid_shrink();
    configure_grid(1'b1, pick_coef(), pick_coef(), 32'd4, 32'd4);
    repeat (15) push_point(pick_q428(), pick_q428());
    drain_core();
    set_register(REG_ROW_COUNT, 32'd1);
    set_register(REG_COL_COUNT, 32'd2);
    push_point(pick_q428(), pick_q428());
  endtask

  // receiver stops for a long stretch while the sender keeps offering
  task automatic test_receiver_hold();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    configure_grid(1'($urandom()), pick_coef(), pick_coef(), 32'd5, 32'd8);
    @(posedge clk);
    hold_left = 150;
    push_random_grid();
  endtask

  task automatic test_random_grids();
    int n;
    int grid_no;
    logic [31:0] rows_reg, cols_reg;
    n       = 0;
    grid_no = 0;
    while (n < RANDOM_ITEMS) begin
      if (n < RANDOM_ITEMS / 3) begin
        send_idle_pct = 22;
        recv_idle_pct = 45;
      end else if (n < 2 * RANDOM_ITEMS / 3) begin
        send_idle_pct = 45;
        recv_idle_pct = 22;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      rows_reg = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 6);
      cols_reg = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 9);
      // widest and tallest grids once each, the register value at or above the limit
      if (grid_no == 0) begin
        rows_reg = 3;
        cols_reg = $urandom_range(64, 127);
      end else if (grid_no == 1) begin
        rows_reg = $urandom_range(64, 127);
        cols_reg = 3;
      end
      configure_grid(1'($urandom()), pick_coef(), pick_coef(), rows_reg, cols_reg);
      push_random_grid();
      n += counts_in_use(rows_reg, MAX_ROWS) * counts_in_use(cols_reg, MAX_COLS);
      grid_no++;
    end
  endtask

  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left--;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_points.size() == 0) begin
        flag_failure("unexpected result", '0, out_tdata);
      end else begin
        front_point = expected_points.pop_front();
        if (out_tdata !== front_point.value)
          flag_failure("new_value", front_point.value, out_tdata);
        if (out_tuser !== front_point.grid_end)
          flag_failure("grid_end", 32'(front_point.grid_end), 32'(out_tuser));
        if (out_tlast !== front_point.last)
          flag_failure("last", 32'(front_point.last), 32'(out_tlast));
      end
      results_seen++;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, expected_points.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    send_idle_pct = 22;
    recv_idle_pct = 45;
    test_register_reset_values();
    test_saturation_and_boundaries();
    test_mid_grid_shrink();
    test_receiver_hold();
    test_random_grids();
    drain_core();
    $display("%0d input transactions, %0d results, %0d grids: saturation, boundaries,",
             items_sent, results_seen, grids_run);
    $display("clamped counts, mid-grid shrink, largest grids, idling and a long stall");
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- filelist.f -----
src/lsh_pkg.sv
src/lsh_line_bank.sv
src/lsh_scale_lane.sv
src/laplacian_stencil_half_step_core.sv
dv/laplacian_stencil_half_step_core_test.sv
